FILE: hw/rtl/psrf_pkg.sv
// ----------------------------------------------------------------------------
// psrf_pkg: shared types and constants of the point self-region filter
// widths, register indexes, configuration record and fixed rotor centres
// ----------------------------------------------------------------------------
`default_nettype none

package psrf_pkg;

	localparam int COORD_W    = 20;
	localparam int TALLY_W    = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int HALF_W     = 16;
	localparam int ZBOUND_W   = 16;
	localparam int RAD_W      = 12;
	localparam int RSQ_W      = 2 * RAD_W;
	localparam int ROTOR_N    = 4;

	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	// rotor centres in the body frame, millimetres
	localparam logic signed [COORD_W:0] ROTOR_CX [ROTOR_N] = '{
		21'sd130, -21'sd130, 21'sd130, -21'sd130
	};
	localparam logic signed [COORD_W:0] ROTOR_CY [ROTOR_N] = '{
		-21'sd220, 21'sd200, 21'sd220, -21'sd200
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BODY_HALF_WIDTH_X      = 3'd0,
		REG_BODY_HALF_WIDTH_Y      = 3'd1,
		REG_BODY_FLOOR_Z           = 3'd2,
		REG_BODY_CEILING_Z         = 3'd3,
		REG_ROTOR_DISC_RADIUS      = 3'd4,
		REG_ROTOR_PLANE_Z          = 3'd5,
		REG_ROTOR_SLAB_HALF_HEIGHT = 3'd6,
		REG_FILTER_ENABLE          = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [HALF_W-1:0]          body_half_width_x;
		logic [HALF_W-1:0]          body_half_width_y;
		logic signed [ZBOUND_W-1:0] body_floor_z;
		logic signed [ZBOUND_W-1:0] body_ceiling_z;
		logic [RAD_W-1:0]           rotor_disc_radius;
		logic [RSQ_W-1:0]           rotor_radius_sq;
		logic signed [ZBOUND_W-1:0] rotor_plane_z;
		logic [RAD_W-1:0]           rotor_slab_half_height;
		logic                       filter_enable;
	} cfg_t;

	localparam logic [RAD_W-1:0] RESET_RADIUS = 12'd148;

	localparam cfg_t CFG_RESET = '{
		body_half_width_x:      16'd255,
		body_half_width_y:      16'd255,
		body_floor_z:           -16'sd140,
		body_ceiling_z:         16'sd10,
		rotor_disc_radius:      RESET_RADIUS,
		rotor_radius_sq:        RSQ_W'(RESET_RADIUS) * RSQ_W'(RESET_RADIUS),
		rotor_plane_z:          -16'sd42,
		rotor_slab_half_height: 12'd35,
		filter_enable:          1'b1
	};

	// magnitude of a sign-extended coordinate difference
	function automatic logic [COORD_W:0] mag_of(input logic signed [COORD_W:0] v);
		logic signed [COORD_W:0] n;
		n = -v;
		return v[COORD_W] ? n : v;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/psrf_if.sv
// ----------------------------------------------------------------------------
// psrf_if: point and result channels
// valid/ready channels carrying one lidar point and one marked result
// ----------------------------------------------------------------------------
`default_nettype none

interface psrf_point_if
	import psrf_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic                      cloud_end;

	modport source (output valid, point_x, point_y, point_z, cloud_end, input ready);
	modport sink   (input valid, point_x, point_y, point_z, cloud_end, output ready);
endinterface

interface psrf_result_if
	import psrf_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;
	logic                      is_self;
	logic [TALLY_W-1:0]        removed_so_far;
	logic                      out_end;

	modport source (output valid, out_x, out_y, out_z, is_self, removed_so_far, out_end,
		input ready);
	modport sink   (input valid, out_x, out_y, out_z, is_self, removed_so_far, out_end,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/psrf_hit_test.sv
// ----------------------------------------------------------------------------
// psrf_hit_test: body box and rotor disc test
// combinational self-hit decision for one point against the current settings
// ----------------------------------------------------------------------------
`default_nettype none

module psrf_hit_test
	import psrf_pkg::*;
(
	input  wire logic signed [COORD_W-1:0] x,
	input  wire logic signed [COORD_W-1:0] y,
	input  wire logic signed [COORD_W-1:0] z,
	input  wire cfg_t                      cfg,
	output logic                           hit
);

	logic signed [COORD_W:0]   x_ext, y_ext, z_ext;
	logic signed [COORD_W:0]   floor_ext, ceil_ext, plane_ext, dz;
	logic [COORD_W:0]          mag_x, mag_y, mag_dz;
	logic                      in_body, in_slab;
	logic [ROTOR_N-1:0]        in_disc;

	assign x_ext     = {x[COORD_W-1], x};
	assign y_ext     = {y[COORD_W-1], y};
	assign z_ext     = {z[COORD_W-1], z};
	assign floor_ext = {{(COORD_W+1-ZBOUND_W){cfg.body_floor_z[ZBOUND_W-1]}}, cfg.body_floor_z};
	assign ceil_ext  = {{(COORD_W+1-ZBOUND_W){cfg.body_ceiling_z[ZBOUND_W-1]}},
		cfg.body_ceiling_z};
	assign plane_ext = {{(COORD_W+1-ZBOUND_W){cfg.rotor_plane_z[ZBOUND_W-1]}},
		cfg.rotor_plane_z};

	assign mag_x  = mag_of(x_ext);
	assign mag_y  = mag_of(y_ext);
	assign dz     = z_ext - plane_ext;
	assign mag_dz = mag_of(dz);

	// inclusive bounds; a floor above the ceiling never matches
	assign in_body = (mag_x <= (COORD_W+1)'(cfg.body_half_width_x))
		&& (mag_y <= (COORD_W+1)'(cfg.body_half_width_y))
		&& (z_ext >= floor_ext) && (z_ext <= ceil_ext);

	assign in_slab = mag_dz <= (COORD_W+1)'(cfg.rotor_slab_half_height);

	// one lane per rotor; an offset beyond the radius misses without squaring
	for (genvar i = 0; i < ROTOR_N; i++) begin : g_rotor
		logic signed [COORD_W:0] dx, dy;
		logic [COORD_W:0]        mdx, mdy;
		logic [RSQ_W-1:0]        sq_x, sq_y;
		logic [RSQ_W:0]          dist_sq;
		logic                    near;

		assign dx      = x_ext - ROTOR_CX[i];
		assign dy      = y_ext - ROTOR_CY[i];
		assign mdx     = mag_of(dx);
		assign mdy     = mag_of(dy);
		assign near    = (mdx <= (COORD_W+1)'(cfg.rotor_disc_radius))
			&& (mdy <= (COORD_W+1)'(cfg.rotor_disc_radius));
		assign sq_x    = RSQ_W'(mdx[RAD_W-1:0]) * RSQ_W'(mdx[RAD_W-1:0]);
		assign sq_y    = RSQ_W'(mdy[RAD_W-1:0]) * RSQ_W'(mdy[RAD_W-1:0]);
		assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
		assign in_disc[i] = near && (dist_sq <= {1'b0, cfg.rotor_radius_sq});
	end

	assign hit = in_body || (in_slab && (|in_disc));

endmodule

`default_nettype wire

FILE: hw/rtl/point_self_region_filter_core.sv
// ----------------------------------------------------------------------------
// point_self_region_filter_core: lidar self-hit filter
// marks points inside the body box or a rotor disc and keeps a per-cloud tally
// ----------------------------------------------------------------------------
// pipeline: a point passes through the input register and then the result
//   register, which offers it on the result channel
// throughput: one point per cycle, set by the single input register and the
//   single result register, both advancing whenever the result side is free
// reset: arst_n clears the valid flags and the removed tally and loads the
//   register defaults; point and result payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module point_self_region_filter_core
	import psrf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	psrf_point_if.sink                 points,
	psrf_result_if.source              results,
	input  wire logic                  write_enable,
	input  wire logic [CFG_IDX_W-1:0]  reg_index,
	input  wire logic [CFG_DATA_W-1:0] write_data
);

	// configuration registers
	cfg_t cfg_q;

	// input stage
	logic                      valid_s1;
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic                      end_s1;

	// result stage
	logic                      valid_s2;
	logic signed [COORD_W-1:0] x_s2, y_s2, z_s2;
	logic                      self_s2;
	logic [TALLY_W-1:0]        removed_s2;
	logic                      end_s2;

	// running count of removed points in the current cloud
	logic [TALLY_W-1:0]        tally_q;

	logic                      adv_s1, adv_s2, move_s1;
	logic                      hit_s1, self_s1;
	logic [TALLY_W-1:0]        tally_next;
	logic [RAD_W-1:0]          new_radius;

	// register writes; the radius square is kept alongside the radius
	assign new_radius = write_data[RAD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (write_enable) begin
			case (reg_index)
				REG_BODY_HALF_WIDTH_X: begin
					cfg_q.body_half_width_x <= write_data[HALF_W-1:0];
				end
				REG_BODY_HALF_WIDTH_Y: begin
					cfg_q.body_half_width_y <= write_data[HALF_W-1:0];
				end
				REG_BODY_FLOOR_Z: begin
					cfg_q.body_floor_z <= write_data[ZBOUND_W-1:0];
				end
				REG_BODY_CEILING_Z: begin
					cfg_q.body_ceiling_z <= write_data[ZBOUND_W-1:0];
				end
				REG_ROTOR_DISC_RADIUS: begin
					cfg_q.rotor_disc_radius <= new_radius;
					cfg_q.rotor_radius_sq   <= RSQ_W'(new_radius) * RSQ_W'(new_radius);
				end
				REG_ROTOR_PLANE_Z: begin
					cfg_q.rotor_plane_z <= write_data[ZBOUND_W-1:0];
				end
				REG_ROTOR_SLAB_HALF_HEIGHT: begin
					cfg_q.rotor_slab_half_height <= write_data[RAD_W-1:0];
				end
				REG_FILTER_ENABLE: begin
					cfg_q.filter_enable <= write_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// flow control: each stage moves on when the stage after it is empty or
	// is itself handing its contents on in this cycle
	assign adv_s2       = !valid_s2 || results.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign move_s1      = valid_s1 && adv_s2;
	assign points.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= points.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && points.valid) begin
			x_s1   <= points.point_x;
			y_s1   <= points.point_y;
			z_s1   <= points.point_z;
			end_s1 <= points.cloud_end;
		end
	end

	// region test on the registered point
	psrf_hit_test u_hit (
		.x   (x_s1),
		.y   (y_s1),
		.z   (z_s1),
		.cfg (cfg_q),
		.hit (hit_s1)
	);

	assign self_s1 = cfg_q.filter_enable && hit_s1;

	// tally includes this point and holds at its maximum
	assign tally_next = (self_s1 && (tally_q != TALLY_MAX)) ? tally_q + 1'b1 : tally_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			tally_q  <= '0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (move_s1) begin
				// cleared after the last point of a cloud
				tally_q <= end_s1 ? '0 : tally_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			x_s2       <= x_s1;
			y_s2       <= y_s1;
			z_s2       <= z_s1;
			self_s2    <= self_s1;
			removed_s2 <= tally_next;
			end_s2     <= end_s1;
		end
	end

	assign results.valid          = valid_s2;
	assign results.out_x          = x_s2;
	assign results.out_y          = y_s2;
	assign results.out_z          = z_s2;
	assign results.is_self        = self_s2;
	assign results.removed_so_far = removed_s2;
	assign results.out_end        = end_s2;

endmodule

`default_nettype wire

FILE: hw/rtl/psrf_checker.sv
// ----------------------------------------------------------------------------
// psrf_checker: port-level checks of the filter core
// result stability under stall and tally progression between results
// ----------------------------------------------------------------------------
`default_nettype none

module psrf_checker
	import psrf_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire logic               is_self,
	input wire logic [TALLY_W-1:0] removed_so_far,
	input wire logic               out_end
);

	logic res_xfer;

	assign res_xfer = res_valid && res_ready;

	// a stalled result keeps its mark, tally and end flag
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(removed_so_far)
			&& $stable(is_self) && $stable(out_end))
	else $error("result changed while stalled");

	// a marked point is always counted
	a_self_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_self |-> removed_so_far != '0)
	else $error("self point with zero tally");

	// back-to-back results within a cloud: tally grows by one per self point
	a_tally_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && $past(res_xfer) && !$past(out_end) && $past(arst_n)
			|-> removed_so_far == (is_self && ($past(removed_so_far) != TALLY_MAX)
				? $past(removed_so_far) + 1'b1 : $past(removed_so_far)))
	else $error("tally step wrong");

	// first result after a cloud end starts from zero
	a_tally_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer && $past(res_xfer) && $past(out_end) && $past(arst_n)
			|-> removed_so_far == (is_self ? TALLY_W'(1) : TALLY_W'(0)))
	else $error("tally not cleared after cloud end");

endmodule

bind point_self_region_filter_core psrf_checker u_psrf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (results.valid),
	.res_ready      (results.ready),
	.is_self        (results.is_self),
	.removed_so_far (results.removed_so_far),
	.out_end        (results.out_end)
);

`default_nettype wire

FILE: verif/psrf_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrf_result_checker: scoreboard for the point self-region filter
// watches the register port and both channels, predicts the mark and the
// per-cloud tally of each point transfer, and compares every result transfer
// ----------------------------------------------------------------------------

module psrf_result_checker
	import psrf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	psrf_point_if                 points,
	psrf_result_if                results,
	input  logic                  write_enable,
	input  logic [CFG_IDX_W-1:0]  reg_index,
	input  logic [CFG_DATA_W-1:0] write_data,
	output int                    mismatches,
	output int                    pending
);

	localparam int MAX_REPORTS = 10;
	localparam logic [TALLY_W-1:0] TALLY_FULL = {TALLY_W{1'b1}};

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      self_mark;
		logic [TALLY_W-1:0]        tally;
		logic                      last;
	} marked_point_t;

	logic [15:0]        half_x;
	logic [15:0]        half_y;
	logic signed [15:0] floor_z;
	logic signed [15:0] ceiling_z;
	logic [11:0]        disc_radius;
	logic signed [15:0] plane_z;
	logic [11:0]        slab_half;
	logic               marking_on;
	logic [TALLY_W-1:0] self_count;

	marked_point_t awaited_results[$];

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// body box, else rotor slab plus any of the four discs
	function automatic logic lands_on_vehicle(input longint x, input longint y,
		input longint z);
		longint r2;
		longint cx;
		longint cy;
		logic   hit;
		hit = 1'b0;
		r2  = longint'(disc_radius) * longint'(disc_radius);
		if (magnitude(x) <= longint'(half_x) && magnitude(y) <= longint'(half_y) &&
			z >= longint'(floor_z) && z <= longint'(ceiling_z)) begin
			hit = 1'b1;
		end else if (magnitude(z - longint'(plane_z)) <= longint'(slab_half)) begin
			for (int k = 0; k < 4; k++) begin
				case (k)
					0: begin cx = 130;  cy = -220; end
					1: begin cx = -130; cy = 200;  end
					2: begin cx = 130;  cy = 220;  end
					default: begin cx = -130; cy = -200; end
				endcase
				if ((x - cx) * (x - cx) + (y - cy) * (y - cy) <= r2)
					hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic marked_point_t mark_point(input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z,
		input logic last);
		marked_point_t m;
		m.x         = x;
		m.y         = y;
		m.z         = z;
		m.last      = last;
		m.self_mark = marking_on && lands_on_vehicle(x, y, z);
		if (m.self_mark && self_count != TALLY_FULL)
			self_count = self_count + 1'b1;
		m.tally = self_count;
		if (last)
			self_count = '0;
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		marked_point_t want;
		if (!arst_n) begin
			half_x      = 16'd255;
			half_y      = 16'd255;
			floor_z     = -16'sd140;
			ceiling_z   = 16'sd10;
			disc_radius = 12'd148;
			plane_z     = -16'sd42;
			slab_half   = 12'd35;
			marking_on  = 1'b1;
			self_count  = '0;
			awaited_results.delete();
			mismatches  = 0;
			pending     = 0;
		end else begin
			if (write_enable) begin
				case (reg_index)
					REG_BODY_HALF_WIDTH_X:      half_x      = write_data[15:0];
					REG_BODY_HALF_WIDTH_Y:      half_y      = write_data[15:0];
					REG_BODY_FLOOR_Z:           floor_z     = write_data[15:0];
					REG_BODY_CEILING_Z:         ceiling_z   = write_data[15:0];
					REG_ROTOR_DISC_RADIUS:      disc_radius = write_data[11:0];
					REG_ROTOR_PLANE_Z:          plane_z     = write_data[15:0];
					REG_ROTOR_SLAB_HALF_HEIGHT: slab_half   = write_data[11:0];
					REG_FILTER_ENABLE:          marking_on  = write_data[0];
					default: ;
				endcase
			end

			if (points.valid && points.ready)
				awaited_results.push_back(mark_point(points.point_x, points.point_y,
					points.point_z, points.cloud_end));

			if (results.valid && results.ready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result transfer with none awaited: x=%0d y=%0d z=%0d",
							$realtime, results.out_x, results.out_y, results.out_z);
				end else begin
					want = awaited_results.pop_front();
					if (results.out_x !== want.x || results.out_y !== want.y ||
						results.out_z !== want.z || results.is_self !== want.self_mark ||
						results.removed_so_far !== want.tally ||
						results.out_end !== want.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: expected x=%0d y=%0d z=%0d self=%0b tally=%0d end=%0b",
								$realtime, want.x, want.y, want.z, want.self_mark,
								want.tally, want.last);
							$display("%0t:      got x=%0d y=%0d z=%0d self=%0b tally=%0d end=%0b",
								$realtime, results.out_x, results.out_y, results.out_z,
								results.is_self, results.removed_so_far, results.out_end);
						end
					end
				end
			end
			pending = awaited_results.size();
		end
	end

endmodule

FILE: verif/point_self_region_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_self_region_filter_core_tb: top of the self-region filter bench
// drives points and register writes, applies random idling and back-pressure
// on the result side, and reports the verdict from the result checker
// ----------------------------------------------------------------------------

module point_self_region_filter_core_tb;
	import psrf_pkg::*;

	localparam int HOLD_OFF_CYCLES   = 400;
	localparam int PHASE_POINTS      = 285;
	localparam int RANDOM_PHASES     = 6;
	localparam int SETTLE_CYCLES     = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  write_enable;
	reg_index_t            reg_index;
	logic [CFG_DATA_W-1:0] write_data;
	int                    mismatches;
	int                    pending;

	// shared with the result-side process
	logic idling_on      = 1'b1;
	int   hold_off_asked = 0;

	// current register settings, only used to aim the random points
	int cur_hx, cur_hy, cur_fl, cur_ce, cur_rad, cur_pz, cur_sh;

	psrf_point_if  points_ch ();
	psrf_result_if results_ch ();

	point_self_region_filter_core DUT (
		.clk,
		.arst_n,
		.points      (points_ch),
		.results     (results_ch),
		.write_enable,
		.reg_index,
		.write_data
	);

	psrf_result_checker point_audit (
		.clk,
		.arst_n,
		.points      (points_ch),
		.results     (results_ch),
		.write_enable,
		.reg_index,
		.write_data,
		.mismatches,
		.pending
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop in case the block hangs
	initial begin
		#50_000_000;
		$display("FAILURE");
		$finish;
	end

	// result side: random idling, plus a long hold-off whenever one is asked for
	initial begin : result_receiver
		int stall_left;
		int holds_done;
		stall_left = 0;
		holds_done = 0;
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_asked != holds_done) begin
				holds_done = hold_off_asked;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				results_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				results_ch.ready <= !(idling_on && $urandom_range(0, 99) < 32);
			end
		end
	end

	// value spread evenly around a centre, bounds included
	function automatic longint near(input longint centre, input longint span);
		return centre - span + longint'($urandom_range(0, 32'(2 * span)));
	endfunction

	// one point transfer; valid is left high so a back-to-back point keeps it up
	task automatic send_point(input longint x, input longint y, input longint z,
		input logic last);
		while (idling_on && $urandom_range(0, 99) < 32) begin
			points_ch.valid <= 1'b0;
			@(negedge clk);
		end
		points_ch.valid     <= 1'b1;
		points_ch.point_x   <= x[COORD_W-1:0];
		points_ch.point_y   <= y[COORD_W-1:0];
		points_ch.point_z   <= z[COORD_W-1:0];
		points_ch.cloud_end <= last;
		do @(posedge clk); while (!points_ch.ready);
		@(negedge clk);
	endtask

	// stop offering, wait for every awaited result, then let the pipe settle
	task automatic drain();
		points_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		write_enable <= 1'b1;
		reg_index    <= idx;
		write_data   <= data;
		@(negedge clk);
	endtask

	// writes every register; unused upper data bits carry noise
	task automatic apply_settings(input int hx, input int hy, input int fl, input int ce,
		input int rad, input int pz, input int sh, input logic en);
		logic [15:0] noise;
		noise   = 16'($urandom);
		cur_hx  = hx;
		cur_hy  = hy;
		cur_fl  = fl;
		cur_ce  = ce;
		cur_rad = rad;
		cur_pz  = pz;
		cur_sh  = sh;
		put_reg(REG_BODY_HALF_WIDTH_X, hx[15:0]);
		put_reg(REG_BODY_HALF_WIDTH_Y, hy[15:0]);
		put_reg(REG_BODY_FLOOR_Z, fl[15:0]);
		put_reg(REG_BODY_CEILING_Z, ce[15:0]);
		put_reg(REG_ROTOR_DISC_RADIUS, {noise[15:12], rad[11:0]});
		put_reg(REG_ROTOR_PLANE_Z, pz[15:0]);
		put_reg(REG_ROTOR_SLAB_HALF_HEIGHT, {noise[11:8], sh[11:0]});
		put_reg(REG_FILTER_ENABLE, {noise[14:0], en});
		write_enable <= 1'b0;
	endtask

	initial begin : stimulus
		int     n;
		int     k;
		int     z_span;
		longint x, y, z;
		logic   last;

		points_ch.valid     = 1'b0;
		points_ch.point_x   = '0;
		points_ch.point_y   = '0;
		points_ch.point_z   = '0;
		points_ch.cloud_end = 1'b0;
		write_enable        = 1'b0;
		reg_index           = REG_BODY_HALF_WIDTH_X;
		write_data          = '0;
		arst_n              = 1'b0;
		cur_hx  = 255;
		cur_hy  = 255;
		cur_fl  = -140;
		cur_ce  = 10;
		cur_rad = 148;
		cur_pz  = -42;
		cur_sh  = 35;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: body box edges, rotor rims and slab faces, field extremes
		send_point(0, 0, 0, 1'b0);
		send_point(255, -255, -140, 1'b0);
		send_point(-256, 0, 0, 1'b0);
		send_point(0, 0, 11, 1'b0);
		send_point(0, 255, -141, 1'b0);
		send_point(278, -220, -42, 1'b0);
		send_point(279, -220, -42, 1'b0);
		send_point(-130, 348, -77, 1'b0);
		send_point(-130, 348, -78, 1'b0);
		send_point(130, -368, -7, 1'b0);
		send_point(524287, 524287, 524287, 1'b0);
		send_point(-524288, -524288, -524288, 1'b1);
		// one-point cloud: tally shown then cleared
		send_point(0, 0, 0, 1'b1);
		drain();

		// filter disabled: nothing marked, tally holds
		apply_settings(255, 255, -140, 10, 148, -42, 35, 1'b0);
		send_point(0, 0, 0, 1'b0);
		send_point(278, -220, -42, 1'b1);
		drain();

		// floor above ceiling: body box is empty
		apply_settings(255, 255, 100, -100, 148, -42, 35, 1'b1);
		send_point(0, 0, 0, 1'b0);
		send_point(0, 0, -42, 1'b0);
		send_point(130, -220, -42, 1'b1);
		drain();

		// every register at its top or bottom extreme
		apply_settings(65535, 65535, -32768, 32767, 4095, 32767, 4095, 1'b1);
		send_point(65535, -65535, -32768, 1'b0);
		send_point(65536, 0, 0, 1'b0);
		send_point(130 + 4095, -220, 32767 + 4095, 1'b1);
		drain();

		// zero sizes: only exact centres and the zero point hit
		apply_settings(0, 0, 0, 0, 0, 0, 0, 1'b1);
		send_point(0, 0, 0, 1'b0);
		send_point(130, -220, 0, 1'b0);
		send_point(131, -220, 0, 1'b1);
		drain();

		// random phases, each with its own settings
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: apply_settings(255, 255, -140, 10, 148, -42, 35, 1'b1);
				1, 2, 3: apply_settings($urandom_range(0, 600), $urandom_range(0, 600),
					int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
					$urandom_range(0, 400), int'($urandom_range(0, 400)) - 200,
					$urandom_range(0, 100), phase != 2);
				4: apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
					int'($urandom_range(0, 65535)) - 32768,
					int'($urandom_range(0, 65535)) - 32768,
					$urandom_range(0, 4095), int'($urandom_range(0, 65535)) - 32768,
					$urandom_range(0, 4095), 1'b1);
				default: apply_settings($urandom_range(0, 3), $urandom_range(0, 3),
					int'($urandom_range(0, 3)) - 2, int'($urandom_range(0, 3)) - 1,
					$urandom_range(0, 3), int'($urandom_range(0, 4)) - 2,
					$urandom_range(0, 2), 1'b1);
			endcase
			// one phase runs flat out on both sides
			idling_on = (phase != 3);

			for (n = 0; n < PHASE_POINTS; n++) begin
				// long result-side hold-off while points keep coming
				if (phase == 1 && n == 100)
					hold_off_asked++;
				last = ($urandom_range(0, 15) == 0);
				case ($urandom_range(0, 9))
					0, 1: begin
						// anywhere in the coordinate range
						x = longint'($urandom);
						y = longint'($urandom);
						z = longint'($urandom);
					end
					2, 3, 4: begin
						// around the body box and its faces
						z_span = (cur_ce > cur_fl) ? cur_ce - cur_fl : cur_fl - cur_ce;
						x = near(0, cur_hx + 3);
						y = near(0, cur_hy + 3);
						z = near((cur_fl + cur_ce) / 2, z_span / 2 + 3);
					end
					default: begin
						// around one rotor disc and its slab
						k = $urandom_range(0, ROTOR_N - 1);
						x = near(longint'(ROTOR_CX[k]), cur_rad + 3);
						y = near(longint'(ROTOR_CY[k]), cur_rad + 3);
						z = near(cur_pz, cur_sh + 3);
					end
				endcase
				send_point(x, y, z, last);
			end
			drain();
		end

		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
